### rtl/core/uartrb_pkg.sv
// Shared types and constants for the serial port ring buffer core.
// No dependencies; imported by every module in rtl/core.
package uartrb_pkg;

   localparam int unsigned RX_DEPTH_DEF = 64;
   localparam int unsigned TX_DEPTH_DEF = 128;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned CMD_W        = 3;
   localparam int unsigned RX_LEVEL_W   = 6;
   localparam int unsigned TX_LEVEL_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_LINE_BYTE  = 3'd0,
      CMD_HOST_READ  = 3'd1,
      CMD_HOST_WRITE = 3'd2,
      CMD_TX_READY   = 3'd3,
      CMD_TX_DONE    = 3'd4,
      CMD_RX_FLUSH   = 3'd5
   } cmd_type;

   // Which memory, if any, supplies the result byte.
   typedef enum logic [1:0] {
      OUT_NONE = 2'd0,
      OUT_RX   = 2'd1,
      OUT_TX   = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic                  done_ok;
      logic                  rx_overflow;
      logic                  tx_overflow;
      logic                  framing_flag;
      logic                  overrun_flag;
      logic                  parity_flag;
      logic [RX_LEVEL_W-1:0] rx_level;
      logic [TX_LEVEL_W-1:0] tx_level;
      logic                  tx_full;
      logic                  tx_finished;
      logic                  send_request;
   } status_type;

endpackage

### rtl/core/uart_rx_tx_ring_buffers_core.sv
// Top level of the serial port ring buffer core: control plus two byte memories.
// Depends on uartrb_pkg, uartrb_ctrl and uartrb_ring_mem.
//
//  channel   handshake            word
//  --------  -------------------  -----------------------------------------
//  command   start, busy          req_command, req_data_byte, error bits
//  result    rsp_valid (strobe)   rsp_out_byte, rsp_done_ok, flags, levels
//
// A command is taken when start is high and busy is low; its result word
// appears for one cycle with rsp_valid on the next cycle.
// One command per cycle while busy is low: pointers update at acceptance
// and a read issued then returns its byte through the registered read port.
// busy is high during reset and the cycle after; the memories need no clearing.
// Results cannot be stalled.
module uart_rx_tx_ring_buffers_core #(
   parameter int unsigned RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
   parameter int unsigned TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [uartrb_pkg::CMD_W-1:0]         req_command,
   input  logic [uartrb_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                                 req_framing_error,
   input  logic                                 req_overrun_error,
   input  logic                                 req_parity_error,
   output logic                                 rsp_valid,
   output logic [uartrb_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                                 rsp_done_ok,
   output logic                                 rsp_rx_overflow,
   output logic                                 rsp_tx_overflow,
   output logic                                 rsp_framing_flag,
   output logic                                 rsp_overrun_flag,
   output logic                                 rsp_parity_flag,
   output logic [uartrb_pkg::RX_LEVEL_W-1:0]    rsp_rx_level,
   output logic [uartrb_pkg::TX_LEVEL_W-1:0]    rsp_tx_level,
   output logic                                 rsp_tx_full,
   output logic                                 rsp_tx_finished,
   output logic                                 rsp_send_request
);
   import uartrb_pkg::*;

   localparam int unsigned RX_PW = $clog2(RX_DEPTH);
   localparam int unsigned TX_PW = $clog2(TX_DEPTH);

   logic              rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [RX_PW-1:0]  rx_wr_addr, rx_rd_addr;
   logic [TX_PW-1:0]  tx_wr_addr, tx_rd_addr;
   logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;
   out_sel_type       out_sel;
   status_type        status;

   uartrb_ctrl #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_framing_error (req_framing_error),
      .req_overrun_error (req_overrun_error),
      .req_parity_error  (req_parity_error),
      .rx_wr_en          (rx_wr_en),
      .rx_wr_addr        (rx_wr_addr),
      .rx_rd_en          (rx_rd_en),
      .rx_rd_addr        (rx_rd_addr),
      .tx_wr_en          (tx_wr_en),
      .tx_wr_addr        (tx_wr_addr),
      .tx_rd_en          (tx_rd_en),
      .tx_rd_addr        (tx_rd_addr),
      .rsp_valid         (rsp_valid),
      .out_sel           (out_sel),
      .status            (status)
   );

   uartrb_ring_mem #(
      .DEPTH (RX_DEPTH)
   ) u_rx_mem (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   uartrb_ring_mem #(
      .DEPTH (TX_DEPTH)
   ) u_tx_mem (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   always_comb begin
      unique case (out_sel)
         OUT_RX:  rsp_out_byte = rx_rd_data;
         OUT_TX:  rsp_out_byte = tx_rd_data;
         default: rsp_out_byte = '0;
      endcase
   end

   assign rsp_done_ok      = status.done_ok;
   assign rsp_rx_overflow  = status.rx_overflow;
   assign rsp_tx_overflow  = status.tx_overflow;
   assign rsp_framing_flag = status.framing_flag;
   assign rsp_overrun_flag = status.overrun_flag;
   assign rsp_parity_flag  = status.parity_flag;
   assign rsp_rx_level     = status.rx_level;
   assign rsp_tx_level     = status.tx_level;
   assign rsp_tx_full      = status.tx_full;
   assign rsp_tx_finished  = status.tx_finished;
   assign rsp_send_request = status.send_request;

endmodule

### rtl/core/uartrb_ring_mem.sv
// Byte-wide synchronous ring storage: one write port, one registered read port.
// Depends on uartrb_pkg for the byte width.
module uartrb_ring_mem #(
   parameter int unsigned DEPTH = uartrb_pkg::RX_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [uartrb_pkg::BYTE_W-1:0]     wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [uartrb_pkg::BYTE_W-1:0]     rd_data
);
   import uartrb_pkg::*;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/uartrb_ctrl.sv
// Command decode, ring pointers, line and send flags, and the result status register.
// Depends on uartrb_pkg; drives the two uartrb_ring_mem instances.
module uartrb_ctrl #(
   parameter int unsigned RX_DEPTH = uartrb_pkg::RX_DEPTH_DEF,
   parameter int unsigned TX_DEPTH = uartrb_pkg::TX_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [uartrb_pkg::CMD_W-1:0]        req_command,
   input  logic                                req_framing_error,
   input  logic                                req_overrun_error,
   input  logic                                req_parity_error,
   output logic                                rx_wr_en,
   output logic [$clog2(RX_DEPTH)-1:0]         rx_wr_addr,
   output logic                                rx_rd_en,
   output logic [$clog2(RX_DEPTH)-1:0]         rx_rd_addr,
   output logic                                tx_wr_en,
   output logic [$clog2(TX_DEPTH)-1:0]         tx_wr_addr,
   output logic                                tx_rd_en,
   output logic [$clog2(TX_DEPTH)-1:0]         tx_rd_addr,
   output logic                                rsp_valid,
   output uartrb_pkg::out_sel_type             out_sel,
   output uartrb_pkg::status_type              status
);
   import uartrb_pkg::*;

   localparam int unsigned RX_PW = $clog2(RX_DEPTH);
   localparam int unsigned TX_PW = $clog2(TX_DEPTH);
   localparam int unsigned RX_LW = (RX_PW + 1 > RX_LEVEL_W) ? RX_PW + 1 : RX_LEVEL_W;
   localparam int unsigned TX_LW = (TX_PW + 1 > TX_LEVEL_W) ? TX_PW + 1 : TX_LEVEL_W;
   localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
   localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

   logic [RX_PW-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in, rx_wr_nx, rx_rd_nx;
   logic [TX_PW-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in, tx_wr_nx, tx_rd_nx;
   logic [TX_PW-1:0] tx_wr_in_nx;
   logic             idle_ff, idle_in;
   logic             armed_ff, armed_in;
   logic             busy_ff;
   logic             rsp_valid_ff;
   out_sel_type      out_sel_ff, out_sel_in;
   status_type       status_ff, status_in;
   logic             accept;
   logic [RX_LW-1:0] rx_lvl_wide;
   logic [TX_LW-1:0] tx_lvl_wide;

   assign accept = start && !busy_ff;

   assign rx_wr_nx    = (rx_wr_ff == RX_LAST) ? '0 : rx_wr_ff + 1'b1;
   assign rx_rd_nx    = (rx_rd_ff == RX_LAST) ? '0 : rx_rd_ff + 1'b1;
   assign tx_wr_nx    = (tx_wr_ff == TX_LAST) ? '0 : tx_wr_ff + 1'b1;
   assign tx_rd_nx    = (tx_rd_ff == TX_LAST) ? '0 : tx_rd_ff + 1'b1;
   assign tx_wr_in_nx = (tx_wr_in == TX_LAST) ? '0 : tx_wr_in + 1'b1;

   always_comb begin
      rx_wr_in   = rx_wr_ff;
      rx_rd_in   = rx_rd_ff;
      tx_wr_in   = tx_wr_ff;
      tx_rd_in   = tx_rd_ff;
      idle_in    = idle_ff;
      armed_in   = armed_ff;
      out_sel_in = OUT_NONE;
      rx_wr_en   = 1'b0;
      rx_rd_en   = 1'b0;
      tx_wr_en   = 1'b0;
      tx_rd_en   = 1'b0;
      status_in  = '0;

      if (accept) begin
         unique case (cmd_type'(req_command))
            CMD_LINE_BYTE: begin
               // Full ring wins over line errors: error inputs are not looked at.
               if (rx_wr_nx == rx_rd_ff) begin
                  status_in.rx_overflow = 1'b1;
               end else if (req_framing_error || req_overrun_error || req_parity_error) begin
                  status_in.framing_flag = req_framing_error;
                  status_in.overrun_flag = req_overrun_error;
                  status_in.parity_flag  = req_parity_error;
               end else begin
                  rx_wr_en          = 1'b1;
                  rx_wr_in          = rx_wr_nx;
                  status_in.done_ok = 1'b1;
               end
            end
            CMD_HOST_READ: begin
               if (rx_rd_ff != rx_wr_ff) begin
                  rx_rd_en          = 1'b1;
                  rx_rd_in          = rx_rd_nx;
                  out_sel_in        = OUT_RX;
                  status_in.done_ok = 1'b1;
               end
            end
            CMD_HOST_WRITE: begin
               if (tx_wr_nx == tx_rd_ff) begin
                  status_in.tx_overflow = 1'b1;
               end else begin
                  tx_wr_en          = 1'b1;
                  tx_wr_in          = tx_wr_nx;
                  armed_in          = 1'b1;
                  status_in.done_ok = 1'b1;
               end
            end
            CMD_TX_READY: begin
               if (tx_rd_ff == tx_wr_ff) begin
                  armed_in = 1'b0;
               end else begin
                  tx_rd_en          = 1'b1;
                  tx_rd_in          = tx_rd_nx;
                  idle_in           = 1'b0;
                  out_sel_in        = OUT_TX;
                  status_in.done_ok = 1'b1;
               end
            end
            CMD_TX_DONE: begin
               idle_in = 1'b1;
            end
            CMD_RX_FLUSH: begin
               rx_wr_in = '0;
               rx_rd_in = '0;
            end
            default: begin
            end
         endcase
      end

      rx_lvl_wide = (rx_wr_in >= rx_rd_in)
                  ? RX_LW'(rx_wr_in) - RX_LW'(rx_rd_in)
                  : RX_LW'(RX_DEPTH) - RX_LW'(rx_rd_in) + RX_LW'(rx_wr_in);
      tx_lvl_wide = (tx_wr_in >= tx_rd_in)
                  ? TX_LW'(tx_wr_in) - TX_LW'(tx_rd_in)
                  : TX_LW'(TX_DEPTH) - TX_LW'(tx_rd_in) + TX_LW'(tx_wr_in);

      status_in.rx_level     = rx_lvl_wide[RX_LEVEL_W-1:0];
      status_in.tx_level     = tx_lvl_wide[TX_LEVEL_W-1:0];
      status_in.tx_full      = (tx_wr_in_nx == tx_rd_in);
      status_in.tx_finished  = (tx_wr_in == tx_rd_in) && idle_in;
      status_in.send_request = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff     <= '0;
         rx_rd_ff     <= '0;
         tx_wr_ff     <= '0;
         tx_rd_ff     <= '0;
         idle_ff      <= 1'b1;
         armed_ff     <= 1'b0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         out_sel_ff   <= OUT_NONE;
      end else begin
         rx_wr_ff     <= rx_wr_in;
         rx_rd_ff     <= rx_rd_in;
         tx_wr_ff     <= tx_wr_in;
         tx_rd_ff     <= tx_rd_in;
         idle_ff      <= idle_in;
         armed_ff     <= armed_in;
         // hold off commands for the cycle that follows reset
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         out_sel_ff   <= out_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // Write and read addresses are the current pointers; a byte written by one
   // command is read at the earliest by the next, so no forwarding is needed.
   assign rx_wr_addr = rx_wr_ff;
   assign rx_rd_addr = rx_rd_ff;
   assign tx_wr_addr = tx_wr_ff;
   assign tx_rd_addr = tx_rd_ff;
   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign out_sel    = out_sel_ff;
   assign status     = status_ff;

endmodule

### rtl/core/uartrb_checker.sv
// Port-level checks for the serial port ring buffer core, bound to the top level.
// Depends on uartrb_pkg and uart_rx_tx_ring_buffers_core.
module uartrb_port_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [uartrb_pkg::CMD_W-1:0]         req_command,
   input logic                                 rsp_valid,
   input logic                                 rsp_done_ok,
   input logic                                 rsp_rx_overflow,
   input logic                                 rsp_tx_overflow,
   input logic                                 rsp_tx_full,
   input logic                                 rsp_tx_finished
);
   import uartrb_pkg::*;

   // every accepted command yields a result word on the next cycle
   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("result word missing after accepted command");

   a_no_stray_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result word without an accepted command");

   a_full_not_finished: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tx_full) |-> !rsp_tx_finished)
      else $error("transmit ring reported full and finished");

   a_refused_write_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tx_overflow) |-> (rsp_tx_full && !rsp_done_ok)
         && ($past(req_command) == CMD_HOST_WRITE))
      else $error("write refusal inconsistent with ring state");

   a_rx_drop_not_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rx_overflow) |-> !rsp_done_ok
         && ($past(req_command) == CMD_LINE_BYTE))
      else $error("receive overflow reported with success");

endmodule

bind uart_rx_tx_ring_buffers_core uartrb_port_checker u_uartrb_port_checker (.*);

### bench/uartrb_checker.sv
// Checker for the serial port ring buffer core: watches the command and result channels,
// predicts each result word from its own copy of both rings and compares it field by field.
// Depends on uartrb_pkg.
module uartrb_checker
   import uartrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  req_framing_error,
   input  logic                  req_overrun_error,
   input  logic                  req_parity_error,
   input  logic                  rsp_valid,
   input  logic [BYTE_W-1:0]     rsp_out_byte,
   input  logic                  rsp_done_ok,
   input  logic                  rsp_rx_overflow,
   input  logic                  rsp_tx_overflow,
   input  logic                  rsp_framing_flag,
   input  logic                  rsp_overrun_flag,
   input  logic                  rsp_parity_flag,
   input  logic [RX_LEVEL_W-1:0] rsp_rx_level,
   input  logic [TX_LEVEL_W-1:0] rsp_tx_level,
   input  logic                  rsp_tx_full,
   input  logic                  rsp_tx_finished,
   input  logic                  rsp_send_request,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RXD         = RX_DEPTH_DEF;
   localparam int unsigned TXD         = TX_DEPTH_DEF;
   localparam int          MAX_REPORTS = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      status_type        st;
   } result_word;

   logic [BYTE_W-1:0] rx_bytes [RXD];
   logic [BYTE_W-1:0] tx_bytes [TXD];
   int unsigned       rx_wr, rx_rd, tx_wr, tx_rd;
   logic              line_idle;
   logic              send_armed;
   result_word        expected_words [$];
   int                mismatches = 0;

   assign fail_count = mismatches;

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         if (mismatches < MAX_REPORTS)
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Advance the local rings by one command and build the word it should produce.
   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                                input logic fe, input logic oe, input logic pe,
                                output result_word w);
      int unsigned nx;
      w = '0;
      case (cmd)
         CMD_LINE_BYTE: begin
            nx = (rx_wr + 1) % RXD;
            if (nx == rx_rd) begin
               w.st.rx_overflow = 1'b1;
            end else if (fe || oe || pe) begin
               w.st.framing_flag = fe;
               w.st.overrun_flag = oe;
               w.st.parity_flag  = pe;
            end else begin
               rx_bytes[rx_wr] = data;
               rx_wr = nx;
               w.st.done_ok = 1'b1;
            end
         end
         CMD_HOST_READ: begin
            if (rx_rd != rx_wr) begin
               w.out_byte = rx_bytes[rx_rd];
               rx_rd = (rx_rd + 1) % RXD;
               w.st.done_ok = 1'b1;
            end
         end
         CMD_HOST_WRITE: begin
            nx = (tx_wr + 1) % TXD;
            if (nx == tx_rd) begin
               w.st.tx_overflow = 1'b1;
            end else begin
               tx_bytes[tx_wr] = data;
               tx_wr = nx;
               send_armed = 1'b1;
               w.st.done_ok = 1'b1;
            end
         end
         CMD_TX_READY: begin
            if (tx_rd == tx_wr) begin
               send_armed = 1'b0;
            end else begin
               line_idle = 1'b0;
               w.out_byte = tx_bytes[tx_rd];
               tx_rd = (tx_rd + 1) % TXD;
               w.st.done_ok = 1'b1;
            end
         end
         CMD_TX_DONE:  line_idle = 1'b1;
         CMD_RX_FLUSH: begin
            rx_wr = 0;
            rx_rd = 0;
         end
         default: ;
      endcase
      // Truncate levels to the port widths.
      w.st.rx_level     = RX_LEVEL_W'((rx_wr + RXD - rx_rd) % RXD);
      w.st.tx_level     = TX_LEVEL_W'((tx_wr + TXD - tx_rd) % TXD);
      w.st.tx_full      = ((tx_wr + 1) % TXD) == tx_rd;
      w.st.tx_finished  = (tx_wr == tx_rd) && line_idle;
      w.st.send_request = send_armed;
   endtask

   always @(posedge clock) begin
      result_word want;
      result_word fresh;
      if (reset) begin
         rx_wr      = 0;
         rx_rd      = 0;
         tx_wr      = 0;
         tx_rd      = 0;
         line_idle  = 1'b1;
         send_armed = 1'b0;
         expected_words.delete();
         pending    = 0;
      end else begin
         // Compare first: a word accepted on this edge cannot have its result yet.
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("%0t: result word with nothing expected", $time);
               mismatches++;
            end else begin
               want = expected_words.pop_front();
               check_field("out_byte",     want.out_byte,        rsp_out_byte);
               check_field("done_ok",      want.st.done_ok,      rsp_done_ok);
               check_field("rx_overflow",  want.st.rx_overflow,  rsp_rx_overflow);
               check_field("tx_overflow",  want.st.tx_overflow,  rsp_tx_overflow);
               check_field("framing_flag", want.st.framing_flag, rsp_framing_flag);
               check_field("overrun_flag", want.st.overrun_flag, rsp_overrun_flag);
               check_field("parity_flag",  want.st.parity_flag,  rsp_parity_flag);
               check_field("rx_level",     want.st.rx_level,     rsp_rx_level);
               check_field("tx_level",     want.st.tx_level,     rsp_tx_level);
               check_field("tx_full",      want.st.tx_full,      rsp_tx_full);
               check_field("tx_finished",  want.st.tx_finished,  rsp_tx_finished);
               check_field("send_request", want.st.send_request, rsp_send_request);
            end
         end
         if (start && !busy) begin
            apply_command(req_command, req_data_byte, req_framing_error,
                          req_overrun_error, req_parity_error, fresh);
            expected_words.push_back(fresh);
         end
         pending = expected_words.size();
      end
   end

endmodule

### bench/uart_rx_tx_ring_buffers_core_tb.sv
// Testbench top for the serial port ring buffer core: clock, reset, command stimulus, verdict.
// Depends on uartrb_pkg, uart_rx_tx_ring_buffers_core and uartrb_checker.
module uart_rx_tx_ring_buffers_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uartrb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam int               RANDOM_WORDS = 1000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data;
      logic              fe;
      logic              oe;
      logic              pe;
   } cmd_word;

   typedef enum int {PH_FILL_RX, PH_FILL_TX, PH_DRAIN, PH_MIXED} phase_kind;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [CMD_W-1:0]      req_command;
   logic [BYTE_W-1:0]     req_data_byte;
   logic                  req_framing_error;
   logic                  req_overrun_error;
   logic                  req_parity_error;
   logic                  rsp_valid;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_done_ok;
   logic                  rsp_rx_overflow;
   logic                  rsp_tx_overflow;
   logic                  rsp_framing_flag;
   logic                  rsp_overrun_flag;
   logic                  rsp_parity_flag;
   logic [RX_LEVEL_W-1:0] rsp_rx_level;
   logic [TX_LEVEL_W-1:0] rsp_tx_level;
   logic                  rsp_tx_full;
   logic                  rsp_tx_finished;
   logic                  rsp_send_request;
   int                    fail_count;
   int                    pending;

   uart_rx_tx_ring_buffers_core dut (.*);

   uartrb_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("uart_rx_tx_ring_buffers_core_tb: errors");
      $finish;
   end

   function automatic cmd_word make_word(input logic [CMD_W-1:0] cmd,
                                         input logic [BYTE_W-1:0] data,
                                         input logic [2:0] errs);
      cmd_word w;
      w.cmd  = cmd;
      w.data = data;
      {w.fe, w.oe, w.pe} = errs;
      return w;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic cmd_word random_word(input phase_kind kind);
      int unsigned      r;
      logic [CMD_W-1:0] cmd;
      logic [2:0]       errs;
      r = $urandom_range(0, 99);
      case (kind)
         PH_FILL_RX: begin
            if (r < 85)      cmd = CMD_LINE_BYTE;
            else if (r < 93) cmd = CMD_HOST_READ;
            else             cmd = CMD_W'($urandom_range(CMD_LINE_BYTE, CMD_SPARE_HI));
         end
         PH_FILL_TX: begin
            if (r < 80)      cmd = CMD_HOST_WRITE;
            else if (r < 90) cmd = CMD_TX_READY;
            else             cmd = CMD_W'($urandom_range(CMD_LINE_BYTE, CMD_SPARE_HI));
         end
         PH_DRAIN: begin
            if (r < 40)      cmd = CMD_HOST_READ;
            else if (r < 80) cmd = CMD_TX_READY;
            else if (r < 90) cmd = CMD_TX_DONE;
            else             cmd = CMD_W'($urandom_range(CMD_LINE_BYTE, CMD_SPARE_HI));
         end
         default: begin
            if (r < 3)       cmd = CMD_RX_FLUSH;
            else if (r < 6)  cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            else             cmd = CMD_W'($urandom_range(CMD_LINE_BYTE, CMD_TX_DONE));
         end
      endcase
      // Keep most line bytes clean so the receive ring actually fills.
      if (cmd == CMD_LINE_BYTE)
         errs = ($urandom_range(0, 99) < 12) ? 3'($urandom_range(1, 7)) : 3'b000;
      else
         errs = 3'($urandom_range(0, 7));
      return make_word(cmd, 8'($urandom_range(0, 255)), errs);
   endfunction

   // Entered and left at a falling edge; start stays high across back-to-back words.
   task automatic send_word(input cmd_word w, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command       <= w.cmd;
      req_data_byte     <= w.data;
      req_framing_error <= w.fe;
      req_overrun_error <= w.oe;
      req_parity_error  <= w.pe;
      start             <= 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   initial begin
      cmd_word   directed [$];
      phase_kind kind;
      int        len;
      int        total;
      int        phase_no;
      bit        calm;

      reset             = 1'b1;
      start             = 1'b0;
      req_command       = CMD_LINE_BYTE;
      req_data_byte     = '0;
      req_framing_error = 1'b0;
      req_overrun_error = 1'b0;
      req_parity_error  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty-ring cases, spare codes, error combinations, byte extremes and flush.
      directed.push_back(make_word(CMD_HOST_READ,  8'h00, 3'b000));
      directed.push_back(make_word(CMD_TX_READY,   8'h00, 3'b000));
      directed.push_back(make_word(CMD_TX_DONE,    8'h00, 3'b000));
      directed.push_back(make_word(CMD_SPARE_LO,   8'hFF, 3'b111));
      directed.push_back(make_word(CMD_SPARE_HI,   8'h55, 3'b000));
      directed.push_back(make_word(CMD_LINE_BYTE,  8'h00, 3'b000));
      directed.push_back(make_word(CMD_LINE_BYTE,  8'hFF, 3'b000));
      directed.push_back(make_word(CMD_LINE_BYTE,  8'h11, 3'b100));
      directed.push_back(make_word(CMD_LINE_BYTE,  8'h22, 3'b010));
      directed.push_back(make_word(CMD_LINE_BYTE,  8'h33, 3'b001));
      directed.push_back(make_word(CMD_LINE_BYTE,  8'h44, 3'b111));
      directed.push_back(make_word(CMD_HOST_WRITE, 8'h00, 3'b000));
      directed.push_back(make_word(CMD_HOST_WRITE, 8'hFF, 3'b000));
      directed.push_back(make_word(CMD_TX_READY,   8'h00, 3'b000));
      directed.push_back(make_word(CMD_TX_READY,   8'h00, 3'b000));
      directed.push_back(make_word(CMD_TX_DONE,    8'h00, 3'b000));
      directed.push_back(make_word(CMD_HOST_READ,  8'h00, 3'b000));
      directed.push_back(make_word(CMD_HOST_READ,  8'h00, 3'b000));
      directed.push_back(make_word(CMD_HOST_READ,  8'h00, 3'b000));
      directed.push_back(make_word(CMD_LINE_BYTE,  8'h5A, 3'b000));
      directed.push_back(make_word(CMD_RX_FLUSH,   8'h00, 3'b000));
      directed.push_back(make_word(CMD_HOST_READ,  8'h00, 3'b000));
      directed.push_back(make_word(CMD_HOST_WRITE, 8'h3C, 3'b000));
      directed.push_back(make_word(CMD_TX_READY,   8'h00, 3'b000));
      directed.push_back(make_word(CMD_TX_READY,   8'h00, 3'b000));
      foreach (directed[i]) send_word(directed[i], pick_gap());

      // Fill both rings to overflow and drain them first, then random phases.
      total    = 0;
      phase_no = 0;
      while (total < RANDOM_WORDS) begin
         case (phase_no)
            0:       begin kind = PH_FILL_RX; len = 150; end
            1:       begin kind = PH_FILL_TX; len = 200; end
            2:       begin kind = PH_DRAIN;   len = 200; end
            default: begin
               kind = phase_kind'($urandom_range(PH_FILL_RX, PH_MIXED));
               len  = $urandom_range(60, 200);
            end
         endcase
         calm = ($urandom_range(0, 3) == 0);
         repeat (len) send_word(random_word(kind), calm ? 0 : pick_gap());
         total += len;
         phase_no++;
      end

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("uart_rx_tx_ring_buffers_core_tb: clean");
      else
         $display("uart_rx_tx_ring_buffers_core_tb: errors");
      $finish;
   end

endmodule
